@@ sv/stereo_balance_with_ramp_core_defines.svh @@
// assertion macros for the stereo balance core
// expects clk and rst to be in scope where the macros are used
`ifndef STEREO_BALANCE_WITH_RAMP_CORE_DEFINES_SVH
`define STEREO_BALANCE_WITH_RAMP_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define SBR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define SBR_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define SBR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/sbr_pkg.sv @@
// shared constants, types and state encoding for the stereo balance core
// no dependencies
`default_nettype none
package sbr_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int RAMP_BITS   = 12;
  localparam int TGT_BITS    = 16;
  localparam int BAL_BITS    = 32;
  localparam int BAL_SHIFT   = BAL_BITS - TGT_BITS;
  localparam int GAIN_BITS   = 31;
  localparam int FRAC_BITS   = 30;
  localparam int DIV_BITS    = BAL_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);
  localparam int MUL_CNT_BITS = $clog2(SAMPLE_BITS + 1);
  localparam int PROD_BITS   = GAIN_BITS + SAMPLE_BITS;

  localparam logic [RAMP_BITS-1:0] RAMP_RESET = RAMP_BITS'(240);
  localparam logic signed [TGT_BITS-1:0] TGT_MAX = 16'sd16384;
  localparam logic signed [TGT_BITS-1:0] TGT_MIN = -16'sd16384;
  localparam logic signed [BAL_BITS-1:0] BAL_ONE = 32'sh4000_0000;
  localparam logic signed [BAL_BITS-1:0] BAL_MINUS_ONE = -32'sh4000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STEP,
    ST_LOAD,
    ST_MUL,
    ST_HOLD
  } sbr_state_t;

  // control from the sequencer to a serial unit, and status back
  typedef struct packed {
    logic start;
  } sbr_unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sbr_unit_sts_t;

endpackage
`default_nettype wire

@@ sv/sbr_ifs.sv @@
// valid/ready channel interfaces for frames, results and the ramp register
// depends on sbr_pkg
`default_nettype none
interface sbr_frame_if;
  import sbr_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic signed [TGT_BITS-1:0]    target_balance;
  modport source (output valid, left_sample, right_sample, target_balance, input ready);
  modport sink (input valid, left_sample, right_sample, target_balance, output ready);
endinterface

interface sbr_result_if;
  import sbr_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  modport source (output valid, left_out, right_out, input ready);
  modport sink (input valid, left_out, right_out, output ready);
endinterface

interface sbr_cfg_if;
  import sbr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [RAMP_BITS-1:0] ramp_length;
  modport source (output valid, ramp_length, input ready);
  modport sink (input valid, ramp_length, output ready);
endinterface
`default_nettype wire

@@ sv/sbr_div.sv @@
// restoring serial divider, one quotient bit per cycle
// depends on sbr_pkg
`default_nettype none
module sbr_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire sbr_pkg::sbr_unit_ctl_t         ctl,
  input  wire logic [sbr_pkg::DIV_BITS-1:0]   dividend,
  input  wire logic [sbr_pkg::RAMP_BITS-1:0]  divisor,
  output sbr_pkg::sbr_unit_sts_t              sts,
  output logic [sbr_pkg::DIV_BITS-1:0]        quotient
);
  import sbr_pkg::*;

  logic                    busy;
  logic                    done;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [RAMP_BITS-1:0]    rem;
  logic [RAMP_BITS-1:0]    dvs;
  logic [DIV_BITS-1:0]     quo;
  logic [RAMP_BITS:0]      trial;
  logic [RAMP_BITS:0]      trial_sub;
  logic                    fits;

  // trial subtraction of the divisor from the shifted remainder
  always_comb begin
    trial     = {rem, quo[DIV_BITS-1]};
    trial_sub = trial - {1'b0, dvs};
    fits      = trial >= {1'b0, dvs};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_BITS'(DIV_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? trial_sub[RAMP_BITS-1:0] : trial[RAMP_BITS-1:0];
      quo <= {quo[DIV_BITS-2:0], fits};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quotient = quo;

endmodule
`default_nettype wire

@@ sv/sbr_mul.sv @@
// serial shift-add multiplier of a signed sample by a Q1.30 gain, one bit per cycle
// rounds to nearest with ties away from zero; depends on sbr_pkg
`default_nettype none
module sbr_mul (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire sbr_pkg::sbr_unit_ctl_t               ctl,
  input  wire logic signed [sbr_pkg::SAMPLE_BITS-1:0] sample,
  input  wire logic [sbr_pkg::GAIN_BITS-1:0]        gain,
  output sbr_pkg::sbr_unit_sts_t                    sts,
  output logic signed [sbr_pkg::SAMPLE_BITS-1:0]    result
);
  import sbr_pkg::*;

  logic                           busy;
  logic                           done;
  logic [MUL_CNT_BITS-1:0]        cnt;
  logic                           neg;
  logic [GAIN_BITS-1:0]           gn;
  logic [GAIN_BITS-1:0]           hi;
  logic [SAMPLE_BITS-1:0]         lo;
  logic [GAIN_BITS:0]             sum;
  logic [PROD_BITS-1:0]           prod;
  logic [PROD_BITS-FRAC_BITS-1:0] rnd;
  logic [PROD_BITS-FRAC_BITS-1:0] signed_rnd;

  // partial sum for the current multiplier bit
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, gn} : '0);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= MUL_CNT_BITS'(SAMPLE_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == MUL_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // product shift register, multiplier magnitude in the low half
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      neg <= sample[SAMPLE_BITS-1];
      gn  <= gain;
      hi  <= '0;
      lo  <= sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);
    end else if (busy) begin
      hi <= sum[GAIN_BITS:1];
      lo <= {sum[0], lo[SAMPLE_BITS-1:1]};
    end
  end

  // round the magnitude and restore the sign
  always_comb begin
    prod       = {hi, lo};
    rnd        = prod[PROD_BITS-1:FRAC_BITS]
               + (PROD_BITS-FRAC_BITS)'(prod[FRAC_BITS-1]);
    signed_rnd = neg ? -rnd : rnd;
  end

  assign result   = signed_rnd[SAMPLE_BITS-1:0];
  assign sts.busy = busy;
  assign sts.done = done;

endmodule
`default_nettype wire

@@ sv/stereo_balance_with_ramp_core.sv @@
// Stereo balance with a linear ramp. One frame at a time: after a frame is accepted the
// balance steps, the serial multipliers run (one sample bit per cycle) and the result
// word is registered; the next frame is taken once the result register can be loaded.
// A frame whose balance request starts a new ramp first runs the serial step divider
// (one quotient bit per cycle). Synchronous reset clears balance, ramp state and the
// output valid flag; the ramp length register resets to 240 frames.
`default_nettype none
module stereo_balance_with_ramp_core (
  input  wire logic    clk,
  input  wire logic    rst,
  sbr_frame_if.sink    frame_in,
  sbr_result_if.source result_out,
  sbr_cfg_if.sink      cfg
);
  import sbr_pkg::*;

  sbr_state_t state;
  sbr_state_t state_next;

  logic [RAMP_BITS-1:0]          ramp_length;
  logic signed [BAL_BITS-1:0]    cur_bal;
  logic signed [TGT_BITS-1:0]    held_tgt;
  logic signed [BAL_BITS-1:0]    ramp_step;
  logic [RAMP_BITS-1:0]          frames_left;
  logic                          started;
  logic                          step_neg;
  logic signed [SAMPLE_BITS-1:0] ls;
  logic signed [SAMPLE_BITS-1:0] rs;
  logic                          res_valid;
  logic signed [SAMPLE_BITS-1:0] left_res;
  logic signed [SAMPLE_BITS-1:0] right_res;

  logic                          accept;
  logic                          in_ready;
  logic                          res_load;
  logic                          changed;
  logic signed [TGT_BITS-1:0]    tgt;
  logic signed [BAL_BITS-1:0]    tgt_q30;
  logic signed [BAL_BITS:0]      diff;
  logic signed [BAL_BITS:0]      diff_neg;
  logic [DIV_BITS-1:0]           diff_mag;
  logic [RAMP_BITS-1:0]          len_eff;
  logic [GAIN_BITS-1:0]          lgain;
  logic [GAIN_BITS-1:0]          rgain;
  logic signed [BAL_BITS-1:0]    lgain_w;
  logic signed [BAL_BITS-1:0]    rgain_w;

  sbr_unit_ctl_t                 div_ctl;
  sbr_unit_sts_t                 div_sts;
  sbr_unit_ctl_t                 mul_ctl;
  sbr_unit_sts_t                 lmul_sts;
  sbr_unit_sts_t                 rmul_sts;
  logic [DIV_BITS-1:0]           quotient;
  logic signed [SAMPLE_BITS-1:0] left_prod;
  logic signed [SAMPLE_BITS-1:0] right_prod;
  logic                          mul_done;

  assign accept   = frame_in.valid & in_ready;
  assign mul_done = lmul_sts.done & rmul_sts.done;

  // clamp the request and form the ramp distance
  always_comb begin
    if (frame_in.target_balance > TGT_MAX) begin
      tgt = TGT_MAX;
    end else if (frame_in.target_balance < TGT_MIN) begin
      tgt = TGT_MIN;
    end else begin
      tgt = frame_in.target_balance;
    end
    tgt_q30  = {tgt, {BAL_SHIFT{1'b0}}};
    changed  = tgt != held_tgt;
    diff     = {tgt_q30[BAL_BITS-1], tgt_q30} - {cur_bal[BAL_BITS-1], cur_bal};
    diff_neg = -diff;
    diff_mag = diff[BAL_BITS] ? diff_neg[BAL_BITS-1:0] : diff[BAL_BITS-1:0];
    len_eff  = (ramp_length == '0) ? RAMP_BITS'(1) : ramp_length;
  end

  // gains from the current balance
  always_comb begin
    lgain_w = (cur_bal <= 0) ? BAL_ONE : BAL_ONE - cur_bal;
    rgain_w = (cur_bal >= 0) ? BAL_ONE : BAL_ONE + cur_bal;
    lgain   = lgain_w[GAIN_BITS-1:0];
    rgain   = rgain_w[GAIN_BITS-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (started && changed) ? ST_DIV : ST_STEP;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: state_next = ST_LOAD;
      ST_LOAD: state_next = ST_MUL;
      ST_MUL: begin
        if (mul_done) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (res_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready      = 1'b0;
    div_ctl.start = 1'b0;
    mul_ctl.start = 1'b0;
    res_load      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        div_ctl.start = frame_in.valid & started & changed;
      end
      ST_LOAD: mul_ctl.start = 1'b1;
      ST_HOLD: res_load = ~res_valid | result_out.ready;
      ST_DIV, ST_STEP, ST_MUL: ;
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ramp length register
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_length <= RAMP_RESET;
    end else if (cfg.valid) begin
      ramp_length <= cfg.ramp_length;
    end
  end

  // balance and ramp state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_bal     <= '0;
      held_tgt    <= '0;
      ramp_step   <= '0;
      frames_left <= '0;
      started     <= 1'b0;
      step_neg    <= 1'b0;
    end else begin
      if (accept) begin
        if (!started) begin
          cur_bal  <= tgt_q30;
          held_tgt <= tgt;
          started  <= 1'b1;
        end else if (changed) begin
          held_tgt    <= tgt;
          frames_left <= len_eff;
          step_neg    <= diff[BAL_BITS];
        end
      end
      if (state == ST_DIV && div_sts.done) begin
        ramp_step <= step_neg ? -quotient : quotient;
      end
      if (state == ST_STEP && frames_left != '0) begin
        frames_left <= frames_left - 1'b1;
        if (frames_left == RAMP_BITS'(1)) begin
          cur_bal <= {held_tgt, {BAL_SHIFT{1'b0}}};
        end else begin
          cur_bal <= cur_bal + ramp_step;
        end
      end
    end
  end

  // frame samples held while the multipliers run
  always_ff @(posedge clk) begin
    if (accept) begin
      ls <= frame_in.left_sample;
      rs <= frame_in.right_sample;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (result_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      left_res  <= left_prod;
      right_res <= right_prod;
    end
  end

  // serial units
  sbr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (diff_mag),
    .divisor  (len_eff),
    .sts      (div_sts),
    .quotient (quotient)
  );

  sbr_mul u_lmul (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mul_ctl),
    .sample (ls),
    .gain   (lgain),
    .sts    (lmul_sts),
    .result (left_prod)
  );

  sbr_mul u_rmul (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mul_ctl),
    .sample (rs),
    .gain   (rgain),
    .sts    (rmul_sts),
    .result (right_prod)
  );

  assign frame_in.ready       = in_ready;
  assign cfg.ready            = 1'b1;
  assign result_out.valid     = res_valid;
  assign result_out.left_out  = left_res;
  assign result_out.right_out = right_res;

  // checks
`include "stereo_balance_with_ramp_core_defines.svh"
  `SBR_ASSERT_ALWAYS(a_bal_range, (cur_bal <= BAL_ONE) && (cur_bal >= BAL_MINUS_ONE), "balance out of range")
  `SBR_ASSERT_NEXT(a_accept_next, accept, (state == ST_DIV) || (state == ST_STEP), "bad state after accept")
  `SBR_ASSERT_IMPLIES(a_div_done, div_sts.done, state == ST_DIV, "divider finished outside its state")
  `SBR_ASSERT_IMPLIES(a_mul_done, lmul_sts.done || rmul_sts.done, mul_done && (state == ST_MUL), "multipliers out of step")

endmodule
`default_nettype wire
